// ===== rtl/nlp_pkg.sv =====
// Shared types and constants for the next-permutation block.
`timescale 1ns / 1ps
`default_nettype none

package nlp_pkg;

  localparam int MAX_LEN = 16;
  localparam int VAL_W   = 4;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic wr;
    val_t wdata;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_FIND = 4'b0010,
    S_SWAP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/nlp_if.sv =====
// Valid/ready channel interfaces for the element stream in and the result stream out.
`timescale 1ns / 1ps
`default_nettype none

interface nlp_in_if;
  import nlp_pkg::*;
  logic valid;
  logic ready;
  val_t elem_value;
  logic elem_last;
  modport source (output valid, output elem_value, output elem_last, input ready);
  modport sink   (input valid, input elem_value, input elem_last, output ready);
endinterface

interface nlp_out_if;
  import nlp_pkg::*;
  logic valid;
  logic ready;
  val_t out_value;
  logic out_last;
  logic has_next;
  modport source (output valid, output out_value, output out_last, output has_next,
                  input ready);
  modport sink   (input valid, input out_value, input out_last, input has_next,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/nlp_cell.sv =====
// One storage cell of the permutation chain, with its local comparators.
`timescale 1ns / 1ps
`default_nettype none

module nlp_cell (
  input  wire logic              clk,
  input  wire nlp_pkg::cell_ctrl_t ctrl,
  input  wire nlp_pkg::val_t     nb_value,
  input  wire nlp_pkg::val_t     cmp_value,
  output nlp_pkg::val_t          value,
  output logic                   lt_nb,
  output logic                   gt_cmp
);
  import nlp_pkg::*;

  val_t value_r;

  // Loading shifts the chain up by one; the swap writes in place
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value_r <= nb_value;
    end else if (ctrl.wr) begin
      value_r <= ctrl.wdata;
    end
  end

  assign value  = value_r;
  assign lt_nb  = (value_r < nb_value);
  assign gt_cmp = (value_r > cmp_value);

endmodule

`default_nettype wire

// ===== rtl/next_lexicographic_permutation.sv =====
// Top level: streamed next lexicographic permutation over a chain of cells.
// Loading takes one word per cycle; an element past MAX_LEN is dropped.
// After the last word the sequencer finds the pivot (S_FIND) and swaps (S_SWAP), then emits one result per cycle
// while the output is not stalled; the walk reads one cell per result.
// The next sequence is taken once the last result has gone into the output register.
// Synchronous reset clears the sequencer, count and output valid; cell contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module next_lexicographic_permutation (
  input  wire logic clk,
  input  wire logic rst_n,
  nlp_in_if.sink    in_ch,
  nlp_out_if.source out_ch
);
  import nlp_pkg::*;

  // Cells hold the sequence reversed: cell k = element n-1-k
  val_t       cell_val [MAX_LEN];
  val_t       cell_nb  [MAX_LEN];
  cell_ctrl_t cell_ctl [MAX_LEN];
  logic [MAX_LEN-1:0] cell_lt;
  logic [MAX_LEN-1:0] cell_gt;

  state_t state_r, state_nxt;
  cnt_t   load_count_r, load_count_nxt;
  cnt_t   rem_r, rem_nxt;
  idx_t   ptr_r, ptr_nxt;
  logic   desc_r, desc_nxt;
  idx_t   piv_r, piv_nxt;
  val_t   pv_r, pv_nxt;
  logic   found_r, found_nxt;
  logic   flag_r, flag_nxt;

  logic   out_valid_r, out_valid_nxt;
  val_t   out_value_r;
  logic   out_last_r;
  logic   has_next_r;

  logic   in_fire;
  logic   do_shift;
  logic   out_load;
  logic   find_hit;
  idx_t   find_idx;
  val_t   find_val;
  idx_t   part_idx;
  val_t   part_val;

  assign in_ch.ready = (state_r == S_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign do_shift    = in_fire && (load_count_r < cnt_t'(MAX_LEN));
  assign out_load    = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  genvar gi;
  generate
    for (gi = 0; gi < MAX_LEN; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign cell_nb[gi] = in_ch.elem_value;
      end else begin : g_body
        assign cell_nb[gi] = cell_val[gi-1];
      end

      always_comb begin
        cell_ctl[gi].shift = do_shift;
        cell_ctl[gi].wr    = (state_r == S_SWAP) && found_r &&
                             ((idx_t'(gi) == piv_r) || (idx_t'(gi) == part_idx));
        cell_ctl[gi].wdata = (idx_t'(gi) == piv_r) ? part_val : pv_r;
      end

      nlp_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctl[gi]),
        .nb_value  (cell_nb[gi]),
        .cmp_value (pv_r),
        .value     (cell_val[gi]),
        .lt_nb     (cell_lt[gi]),
        .gt_cmp    (cell_gt[gi])
      );
    end
  endgenerate

  // Pivot: lowest cell k >= 1 within the sequence that is below its lower neighbour
  always_comb begin
    find_hit = 1'b0;
    find_idx = '0;
    find_val = '0;
    for (int k = MAX_LEN - 1; k >= 1; k--) begin
      if (cell_lt[k] && (cnt_t'(k) < load_count_r)) begin
        find_hit = 1'b1;
        find_idx = idx_t'(k);
      end
    end
    for (int k = 0; k < MAX_LEN; k++) begin
      if (idx_t'(k) == find_idx) begin
        find_val = cell_val[k];
      end
    end
  end

  // Swap partner: lowest cell below the pivot holding a larger value
  always_comb begin
    part_idx = '0;
    part_val = '0;
    for (int i = MAX_LEN - 1; i >= 0; i--) begin
      if (cell_gt[i] && (idx_t'(i) < piv_r)) begin
        part_idx = idx_t'(i);
      end
    end
    for (int i = 0; i < MAX_LEN; i++) begin
      if (idx_t'(i) == part_idx) begin
        part_val = cell_val[i];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    load_count_nxt = load_count_r;
    rem_nxt        = rem_r;
    ptr_nxt        = ptr_r;
    desc_nxt       = desc_r;
    piv_nxt        = piv_r;
    pv_nxt         = pv_r;
    found_nxt      = found_r;
    flag_nxt       = flag_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end

    unique case (state_r)
      S_LOAD: begin
        if (do_shift) begin
          load_count_nxt = load_count_r + cnt_t'(1);
        end
        if (in_fire && in_ch.elem_last) begin
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        found_nxt = find_hit;
        piv_nxt   = find_idx;
        pv_nxt    = find_val;
        flag_nxt  = find_hit || (load_count_r <= cnt_t'(1));
        state_nxt = S_SWAP;
      end
      S_SWAP: begin
        // Walk: cells n-1 down to pivot, then 0 up to pivot-1 (or 0 up to n-1 on wrap)
        rem_nxt   = load_count_r;
        if (found_r) begin
          ptr_nxt  = idx_t'(load_count_r - cnt_t'(1));
          desc_nxt = 1'b1;
        end else begin
          ptr_nxt  = '0;
          desc_nxt = 1'b0;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          rem_nxt = rem_r - cnt_t'(1);
          if (desc_r) begin
            if (ptr_r == piv_r) begin
              ptr_nxt  = '0;
              desc_nxt = 1'b0;
            end else begin
              ptr_nxt = ptr_r - idx_t'(1);
            end
          end else begin
            ptr_nxt = ptr_r + idx_t'(1);
          end
          if (rem_r == cnt_t'(1)) begin
            load_count_nxt = '0;
            state_nxt      = S_LOAD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      load_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_count_r <= load_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    ptr_r   <= ptr_nxt;
    desc_r  <= desc_nxt;
    piv_r   <= piv_nxt;
    pv_r    <= pv_nxt;
    found_r <= found_nxt;
    flag_r  <= flag_nxt;
    if (out_load) begin
      out_value_r <= cell_val[ptr_r];
      out_last_r  <= (rem_r == cnt_t'(1));
      has_next_r  <= flag_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.out_last  = out_last_r;
  assign out_ch.has_next  = has_next_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_count_r <= cnt_t'(MAX_LEN))
    else $error("load count beyond cell chain");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (rem_r != '0) && (load_count_r != '0))
    else $error("emitting with nothing held");

  a_pivot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWAP) && found_r |-> (piv_r != '0) && (cnt_t'(piv_r) < load_count_r))
    else $error("pivot outside the sequence");

  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (rem_r == cnt_t'(1)) |=> (state_r == S_LOAD) && out_valid_r && out_last_r)
    else $error("final word did not end the walk");

endmodule

`default_nettype wire

// ===== sim/tb_next_lexicographic_permutation.sv =====
// Self-checking testbench for the streamed next-lexicographic-permutation block.
`timescale 1ns / 1ps

module tb_next_lexicographic_permutation;
  import nlp_pkg::*;

  localparam int RANDOM_WORDS   = 140;
  localparam int CALM_WORDS     = 30;
  localparam int DRAIN_CYCLES   = 2 * MAX_LEN + 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef val_t val_q_t[$];

  typedef struct packed {
    val_t value;
    logic last;
    logic has_next;
  } perm_elem_t;

  class perm_scoreboard;
    val_t        held[MAX_LEN];
    cnt_t        held_cnt;
    perm_elem_t  next_perm_q[$];
    int unsigned errors;

    function new();
      held_cnt = '0;
      errors   = 0;
    endfunction

    function void reverse_span(int unsigned lo, int unsigned hi_excl);
      val_t t;
      while (lo + 1 < hi_excl) begin
        hi_excl--;
        t             = held[lo];
        held[lo]      = held[hi_excl];
        held[hi_excl] = t;
        lo++;
      end
    endfunction

    // Rearranges held[0..n) in place; returns 0 when it wrapped to ascending
    function bit advance_arrangement(int unsigned n);
      int unsigned p;
      int unsigned j;
      val_t        t;
      if (n <= 1) return 1'b1;
      p = n - 1;
      while (p > 0 && held[p-1] >= held[p]) p--;
      if (p == 0) begin
        reverse_span(0, n);
        return 1'b0;
      end
      // pivot at p-1, suffix is non-increasing: swap with rightmost larger one
      j = n - 1;
      while (held[j] <= held[p-1]) j--;
      t         = held[p-1];
      held[p-1] = held[j];
      held[j]   = t;
      reverse_span(p, n);
      return 1'b1;
    endfunction

    function void note_word(val_t v, logic last);
      bit          nxt;
      int unsigned n;
      perm_elem_t  e;
      // words past MAX_LEN are dropped, but a dropped last still ends the sequence
      if (held_cnt < MAX_LEN) begin
        held[held_cnt] = v;
        held_cnt++;
      end
      if (!last) return;
      n   = held_cnt;
      nxt = advance_arrangement(n);
      for (int unsigned k = 0; k < n; k++) begin
        e.value    = held[k];
        e.last     = (k + 1 == n);
        e.has_next = nxt;
        next_perm_q.push_back(e);
      end
      held_cnt = '0;
    endfunction

    function void check_result(val_t v, logic last, logic nxt);
      perm_elem_t e;
      if (next_perm_q.size() == 0) begin
        $error("unexpected result word: out_value %0d out_last %0b has_next %0b",
               v, last, nxt);
        errors++;
        return;
      end
      e = next_perm_q.pop_front();
      if (v !== e.value) begin
        $error("out_value: expected %0d, actual %0d", e.value, v);
        errors++;
      end
      if (last !== e.last) begin
        $error("out_last: expected %0b, actual %0b", e.last, last);
        errors++;
      end
      if (nxt !== e.has_next) begin
        $error("has_next: expected %0b, actual %0b", e.has_next, nxt);
        errors++;
      end
    endfunction

    function int outstanding();
      return next_perm_q.size();
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  bit             calm;
  int unsigned    words_sent;
  int unsigned    stall_cycles;
  perm_scoreboard sb = new();

  nlp_in_if  in_ch();
  nlp_out_if out_ch();

  next_lexicographic_permutation u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.elem_value, in_ch.elem_last);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.out_value, out_ch.out_last, out_ch.has_next);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("** next_lexicographic_permutation: FAILED **");
        $finish;
      end
    end
  end

  // Result side back-pressure in bursts
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  task automatic send_word(val_t v, logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.elem_value <= v;
    in_ch.elem_last  <= last;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic send_sequence(val_q_t vals);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  function automatic val_q_t distinct_values(int unsigned n);
    val_t   pool[16];
    val_t   t;
    val_q_t q;
    int unsigned j;
    foreach (pool[i]) pool[i] = val_t'(i);
    for (int i = 15; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (int unsigned i = 0; i < n; i++) q.push_back(pool[i]);
    return q;
  endfunction

  initial begin
    val_q_t      seq;
    int unsigned directed_words;
    int unsigned seq_idx;
    int unsigned kind;
    int unsigned len;
    val_t        base;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.elem_value <= '0;
    in_ch.elem_last  <= 1'b0;
    calm       = 1'b0;
    words_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single elements at both extremes pass through unchanged, then a plain ascending pair
    seq = '{4'd15};          send_sequence(seq);
    seq = '{4'd0};           send_sequence(seq);
    seq = '{4'd0, 4'd1};     send_sequence(seq);
    // descending arrangements wrap to ascending, beside a three-word case with a next arrangement
    seq = '{4'd1, 4'd0};     send_sequence(seq);
    seq = '{4'd2, 4'd3, 4'd1};              send_sequence(seq);
    seq = '{4'd15, 4'd10, 4'd5, 4'd0};      send_sequence(seq);
    // repeated values: strict ascent and strict swap partner
    seq = '{4'd1, 4'd2, 4'd2};              send_sequence(seq);
    seq = '{4'd7, 4'd7, 4'd3};              send_sequence(seq);
    directed_words = words_sent;

    seq_idx = 0;
    while (words_sent < directed_words + RANDOM_WORDS) begin
      calm = (words_sent >= directed_words + RANDOM_WORDS - CALM_WORDS);
      kind = $urandom_range(0, 19);
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      if (seq_idx == 2 || kind == 19) begin
        // overlong: the tail is dropped, including the word that ends it
        seq = distinct_values(16);
        repeat ($urandom_range(1, 5)) seq.push_back(val_t'($urandom_range(0, 15)));
      end else if (kind >= 16) begin
        seq.delete();
        base = val_t'($urandom_range(0, 15));
        repeat (len) seq.push_back(base + val_t'($urandom_range(0, 2)));
      end else begin
        seq = distinct_values(len);
        if (kind >= 14) seq.rsort();
      end
      send_sequence(seq);
      seq_idx++;
    end

    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("** next_lexicographic_permutation: PASSED **");
    else
      $display("** next_lexicographic_permutation: FAILED **");
    $finish;
  end

endmodule
